// ----- rtl/vmt_pkg.sv -----
// Shared types and constants for the 4x4 matrix-vector transform core.
// Used by the cells, the output stage, the top level and the checker.
// No dependencies.
`default_nettype none

package vmt_pkg;

   localparam int PAIR_COUNT = 8;
   localparam int PAIR_W     = 64;
   localparam int CSR_IDX_W  = 8;
   localparam int LANES      = 4;
   localparam int Q_W        = 32;
   localparam int PROD_W     = 2 * Q_W;
   localparam int ACC_W      = PROD_W + 2;
   localparam int FRAC_W     = 16;

   typedef logic signed [Q_W-1:0]    q16_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [ACC_W-1:0]  acc_type;
   typedef logic [PAIR_W-1:0]        pair_type;

   localparam pair_type PAIR_RESET [PAIR_COUNT] = '{
      64'h0000_0000_0001_0000, 64'h0000_0000_0000_0000,
      64'h0001_0000_0000_0000, 64'h0000_0000_0000_0000,
      64'h0000_0000_0000_0000, 64'h0000_0000_0001_0000,
      64'h0000_0000_0000_0000, 64'h0001_0000_0000_0000
   };

   // Input beat. First member is the most significant.
   typedef struct packed {
      q16_type in_x;
      q16_type in_y;
      q16_type in_z;
      q16_type in_w;
   } req_payload_type;

   // Result beat.
   typedef struct packed {
      q16_type out_x;
      q16_type out_y;
      q16_type out_z;
      q16_type out_w;
   } rsp_payload_type;

   // What one cell hands to its neighbor: the vector, rotated so that the
   // component for the next column sits in lane 0, and the four partial sums.
   typedef struct packed {
      q16_type [LANES-1:0] vec;
      acc_type [LANES-1:0] acc;
   } chain_type;

endpackage

`default_nettype wire

// ----- rtl/vmt_cell.sv -----
// One cell of the transform chain: multiplies one matrix column by one
// vector component and adds the products to the running sums. Uses vmt_pkg.
`default_nettype none

module vmt_cell (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire vmt_pkg::q16_type [vmt_pkg::LANES-1:0] coef,
   input  wire logic                          up_valid,
   input  wire vmt_pkg::chain_type            up_data,
   output logic                               up_stall,
   output logic                               dn_valid,
   output vmt_pkg::chain_type                 dn_data,
   input  wire logic                          dn_stall
);
   import vmt_pkg::*;

   logic                  a_valid_ff;
   logic                  a_valid_in;
   chain_type             a_data_ff;
   prod_type [LANES-1:0]  a_prod_ff;
   prod_type [LANES-1:0]  a_prod_in;
   logic                  b_valid_ff;
   logic                  b_valid_in;
   chain_type             b_data_ff;
   chain_type             b_data_in;
   logic                  a_load;
   logic                  b_load;
   q16_type               vec_head;

   assign b_load   = !b_valid_ff || !dn_stall;
   assign a_load   = !a_valid_ff || b_load;
   assign up_stall = !a_load;
   assign vec_head = up_data.vec[0];

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         a_prod_in[i] = PROD_W'(coef[i]) * PROD_W'(vec_head);
      end
      a_valid_in = a_load ? up_valid : a_valid_ff;
      b_valid_in = b_load ? a_valid_ff : b_valid_ff;
      // Rotate so the next column's component lands in lane 0.
      b_data_in.vec = {a_data_ff.vec[0], a_data_ff.vec[LANES-1:1]};
      for (int i = 0; i < LANES; i++) begin
         b_data_in.acc[i] = a_data_ff.acc[i] + ACC_W'(a_prod_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_load) begin
         a_data_ff <= up_data;
         a_prod_ff <= a_prod_in;
      end
      if (b_load) begin
         b_data_ff <= b_data_in;
      end
   end

   assign dn_valid = b_valid_ff;
   assign dn_data  = b_data_ff;

endmodule

`default_nettype wire

// ----- rtl/vmt_sat_stage.sv -----
// Output register of the transform chain: drops the fraction bits of each
// sum, saturates to 32 bits and holds the result beat. Uses vmt_pkg.
`default_nettype none

module vmt_sat_stage (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     up_valid,
   input  wire vmt_pkg::chain_type       up_data,
   output logic                          up_stall,
   output logic                          rsp_valid,
   output vmt_pkg::rsp_payload_type      rsp_data,
   input  wire logic                     rsp_stall
);
   import vmt_pkg::*;

   logic             valid_ff;
   logic             valid_in;
   rsp_payload_type  data_ff;
   rsp_payload_type  data_in;
   q16_type [LANES-1:0] lane_out;
   logic             load;

   // Floor shift by the fraction width, then clamp to the signed 32-bit range.
   // The shifted value fits when its sign bit and all bits above it agree.
   function automatic q16_type sat_lane(input acc_type sum);
      logic [ACC_W-FRAC_W-Q_W:0] top;
      q16_type                   res;
      top = sum[ACC_W-1:FRAC_W+Q_W-1];
      if ((&top) || !(|top)) begin
         res = sum[FRAC_W+Q_W-1:FRAC_W];
      end else if (sum[ACC_W-1]) begin
         res = {1'b1, {(Q_W-1){1'b0}}};
      end else begin
         res = {1'b0, {(Q_W-1){1'b1}}};
      end
      return res;
   endfunction

   assign load     = !valid_ff || !rsp_stall;
   assign up_stall = !load;

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         lane_out[i] = sat_lane(up_data.acc[i]);
      end
      data_in.out_x = lane_out[0];
      data_in.out_y = lane_out[1];
      data_in.out_z = lane_out[2];
      data_in.out_w = lane_out[3];
      valid_in      = load ? up_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

`default_nettype wire

// ----- rtl/vec4_matrix_transform_core.sv -----
// Top level of the 4x4 column-major matrix-vector transform core.
// Depends on vmt_pkg, vmt_cell and vmt_sat_stage.
//
// Usage:
//   The req_ channel carries one beat per vector (in_x, in_y, in_z, in_w,
//   each signed Q16.16); for a point the sender sets in_w to 1.0 (65536).
//   The rsp_ channel returns one beat per vector with component i equal to
//   the sum over j of m[4j+i] * v[j], floored to Q16.16 and saturated.
//   The matrix lives in eight 64-bit registers written through the csr_
//   port; register k holds element 2k in its low half and 2k+1 in its high
//   half. Writes to an index above 7 are ignored. Write the matrix only
//   while no vector is in flight.
// Timing:
//   A row of four identical cells, one per matrix column, passes the vector
//   and the partial sums along. Each cell has a multiply register and an
//   accumulate register, and a final register saturates the sums; an
//   accepted request passes through all of them in that order to the result
//   beat. One beat is accepted every cycle while req_stall is low.
// Reset and flow control:
//   Reset loads the identity matrix and empties the pipeline. A stall on the
//   result side holds the result beat; stages behind it keep filling until
//   the pipeline is full, and only then does req_stall rise.
`default_nettype none

module vec4_matrix_transform_core (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   input  wire vmt_pkg::req_payload_type       req_data,
   output logic                                req_stall,
   output logic                                rsp_valid,
   output vmt_pkg::rsp_payload_type            rsp_data,
   input  wire logic                           rsp_stall,
   input  wire logic                           csr_write_en,
   input  wire logic [vmt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [vmt_pkg::PAIR_W-1:0]     csr_wdata
);
   import vmt_pkg::*;

   localparam int PAIR_IDX_W = $clog2(PAIR_COUNT);

   pair_type  coeff_ff [PAIR_COUNT];
   logic      link_valid [LANES+1];
   logic      link_stall [LANES+1];
   chain_type link_data  [LANES+1];

   // Coefficient registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < PAIR_COUNT; k++) begin
            coeff_ff[k] <= PAIR_RESET[k];
         end
      end else if (csr_write_en && (csr_index < CSR_IDX_W'(PAIR_COUNT))) begin
         coeff_ff[csr_index[PAIR_IDX_W-1:0]] <= csr_wdata;
      end
   end

   // The first cell sees the vector with x in lane 0 and empty sums.
   assign link_valid[0]     = req_valid;
   assign link_data[0].vec  = {req_data.in_w, req_data.in_z, req_data.in_y, req_data.in_x};
   assign link_data[0].acc  = '0;
   assign req_stall         = link_stall[0];

   for (genvar j = 0; j < LANES; j++) begin : g_cell
      q16_type [LANES-1:0] col;

      // Column j holds elements 4j..4j+3, packed two to a register.
      for (genvar i = 0; i < LANES; i++) begin : g_coef
         assign col[i] = coeff_ff[2*j + i/2][(i%2)*Q_W +: Q_W];
      end

      vmt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .coef     (col),
         .up_valid (link_valid[j]),
         .up_data  (link_data[j]),
         .up_stall (link_stall[j]),
         .dn_valid (link_valid[j+1]),
         .dn_data  (link_data[j+1]),
         .dn_stall (link_stall[j+1])
      );
   end

   vmt_sat_stage u_sat (
      .clock     (clock),
      .reset     (reset),
      .up_valid  (link_valid[LANES]),
      .up_data   (link_data[LANES]),
      .up_stall  (link_stall[LANES]),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

endmodule

`default_nettype wire

// ----- rtl/vmt_checker.sv -----
// Port-level checks for the transform core, attached by bind.
// Uses vmt_pkg; binds to vec4_matrix_transform_core.
`default_nettype none

module vmt_checker (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_valid,
   input wire logic                      req_stall,
   input wire logic                      rsp_valid,
   input wire vmt_pkg::rsp_payload_type  rsp_data,
   input wire logic                      rsp_stall
);
   import vmt_pkg::*;

   // A held result beat keeps its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // With the result side open, the input side never stalls.
   a_no_stall: assert property (@(posedge clock)
      !rsp_stall |-> !req_stall)
      else $error("input stalled while output was open");

   // An accepted beat with no stall on the way out passes every cell and the output register to a result beat.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !rsp_stall) ##1 !rsp_stall ##1 !rsp_stall
      ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall
      ##1 !rsp_stall ##1 !rsp_stall |=> rsp_valid)
      else $error("result beat missing after pipeline latency");

endmodule

bind vec4_matrix_transform_core vmt_checker u_vmt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data),
   .rsp_stall (rsp_stall)
);

`default_nettype wire
